/* rtl/afr_pkg.sv */
// Package for the AT final result detector: item classes, status codes,
// keyword table and the per-character match function. No dependencies.
`default_nettype none

package afr_pkg;

    localparam int KW_COUNT        = 8;
    localparam int KW_PREFIX_FIRST = 6;
    localparam int KW_MAX_LEN      = 11;
    localparam int POS_W           = 4;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Right-justified in the word: character p of a keyword of length n
    // sits at bits [8*(n-1-p) +: 8].
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        88'("OK"),
        88'("ERROR"),
        88'("NO CARRIER"),
        88'("NO ANSWER"),
        88'("NO DIALTONE"),
        88'("BUSY"),
        88'("+CME ERROR:"),
        88'("+CMS ERROR:")
    };

    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd5, 4'd10, 4'd9, 4'd11, 4'd4, 4'd11, 4'd11
    };

    localparam int KW_OK = 0;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_OK      = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CLS_CONTENT  = 3'd0,
        CLS_SPACE    = 3'd1,
        CLS_WS_OTHER = 3'd2,
        CLS_LINE_END = 3'd3,
        CLS_BUF_END  = 3'd4
    } t_cls;

    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_SPACE = 2'd1,
        HELD_OTHER = 2'd2
    } t_held;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_BUF_END = 1'b1;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] ch;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_flags;

    typedef struct packed {
        logic [KW_COUNT-1:0] mask;
        logic [POS_W-1:0]    pos;
        t_status             status;
    } t_match;

    function automatic logic [7:0] kw_char(input int k, input logic [POS_W-1:0] pos);
        logic [8*KW_MAX_LEN-1:0] text;
        int                      sh;
        text = KW_TEXT[k];
        sh   = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
        if (pos >= KW_LEN[k]) begin
            return 8'h00;
        end else begin
            return text[sh +: 8];
        end
    endfunction

    // Advance every live keyword by one trimmed-line character; a completed prefix keyword sets the status to error.
    function automatic t_match match_char(input t_match cur, input logic [7:0] ch);
        t_match nxt;
        nxt = cur;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (cur.mask[k] && ((cur.pos >= KW_LEN[k]) || (kw_char(k, cur.pos) != ch))) begin
                nxt.mask[k] = 1'b0;
            end
        end
        if (cur.pos != POS_MAX) begin
            nxt.pos = cur.pos + 1'b1;
        end
        if (cur.status == ST_PENDING) begin
            for (int k = KW_PREFIX_FIRST; k < KW_COUNT; k++) begin
                if (nxt.mask[k] && (nxt.pos == KW_LEN[k])) begin
                    nxt.status = ST_ERROR;
                end
            end
        end
        return nxt;
    endfunction

    // Decide on a whole-line keyword at line end; first match in table order wins.
    function automatic t_status line_close(input t_match cur, input logic seen);
        t_status st;
        logic    hit;
        st  = cur.status;
        hit = 1'b0;
        if (seen && (cur.status == ST_PENDING)) begin
            for (int k = 0; k < KW_PREFIX_FIRST; k++) begin
                if (!hit && cur.mask[k] && (cur.pos == KW_LEN[k])) begin
                    hit = 1'b1;
                    st  = (k == KW_OK) ? ST_OK : ST_ERROR;
                end
            end
        end
        return st;
    endfunction

endpackage

`default_nettype wire

/* rtl/afr_front.sv */
// Front end of the AT final result detector: takes input transactions and
// classifies each byte for the back end. Depends on afr_pkg.
`default_nettype none

module afr_front (
    input  wire logic                  i_in_valid,
    input  wire logic                  i_opcode,
    input  wire logic [7:0]            i_rx_byte,
    input  wire afr_pkg::t_queue_flags i_flags,
    output logic                       o_in_stall,
    output logic                       o_push,
    output afr_pkg::t_item             o_item
);

    assign o_in_stall = i_flags.full;
    assign o_push     = i_in_valid && !i_flags.full;

    always_comb begin
        o_item.ch = i_rx_byte;
        if (i_opcode == afr_pkg::OP_BUF_END) begin
            o_item.cls = afr_pkg::CLS_BUF_END;
        end else begin
            case (i_rx_byte)
                afr_pkg::CH_LF:    o_item.cls = afr_pkg::CLS_LINE_END;
                afr_pkg::CH_SPACE: o_item.cls = afr_pkg::CLS_SPACE;
                afr_pkg::CH_TAB,
                afr_pkg::CH_CR:    o_item.cls = afr_pkg::CLS_WS_OTHER;
                default:           o_item.cls = afr_pkg::CLS_CONTENT;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/afr_queue.sv */
// Short queue of classified items between front and back end.
// Register array with read and write pointers. Depends on afr_pkg.
`default_nettype none

module afr_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire afr_pkg::t_item i_item,
    input  wire logic           i_pop,
    output afr_pkg::t_item      o_item,
    output afr_pkg::t_queue_flags o_flags
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    afr_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end else begin
            return p + 1'b1;
        end
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rd_ptr];
    assign o_flags.full  = (r_count == CNT_W'(DEPTH));
    assign o_flags.empty = (r_count == '0);

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_flags.full && !i_pop))
        else $error("queue written while full");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_flags.empty))
        else $error("queue read while empty");

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

/* rtl/afr_back.sv */
// Back end of the AT final result detector: line trimming, keyword matching,
// sticky status and the output register. Depends on afr_pkg.
`default_nettype none

module afr_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire afr_pkg::t_queue_flags i_flags,
    input  wire afr_pkg::t_item        i_item,
    input  wire logic                  i_out_stall,
    output logic                       o_pop,
    output logic                       o_out_valid,
    output logic [1:0]                 o_status,
    output logic                       o_buffer_done
);

    afr_pkg::t_match  r_line, n_line;
    logic             r_seen, n_seen;
    afr_pkg::t_held   r_held, n_held;
    logic             r_out_valid, n_out_valid;
    afr_pkg::t_status r_status_out, n_status_out;
    logic             r_done_out, n_done_out;

    afr_pkg::t_match  m_sp;
    afr_pkg::t_match  m_ch;
    afr_pkg::t_status close_st;

    // Take the next item whenever the queue holds one and the output register is free or being drained.
    assign o_pop = !i_flags.empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        m_sp = r_line;
        if (r_held == afr_pkg::HELD_SPACE) begin
            m_sp = afr_pkg::match_char(r_line, afr_pkg::CH_SPACE);
        end else if (r_held == afr_pkg::HELD_OTHER) begin
            m_sp.mask = '0;
        end
        m_ch     = afr_pkg::match_char(m_sp, i_item.ch);
        close_st = afr_pkg::line_close(r_line, r_seen);
    end

    always_comb begin
        n_line = r_line;
        n_seen = r_seen;
        n_held = r_held;
        case (i_item.cls)
            afr_pkg::CLS_CONTENT: begin
                n_line = m_ch;
                n_seen = 1'b1;
                n_held = afr_pkg::HELD_NONE;
            end
            afr_pkg::CLS_SPACE: begin
                if (r_seen) begin
                    n_held = (r_held == afr_pkg::HELD_NONE) ? afr_pkg::HELD_SPACE
                                                            : afr_pkg::HELD_OTHER;
                end
            end
            afr_pkg::CLS_WS_OTHER: begin
                if (r_seen) begin
                    n_held = afr_pkg::HELD_OTHER;
                end
            end
            afr_pkg::CLS_LINE_END: begin
                n_line.mask   = '1;
                n_line.pos    = '0;
                n_line.status = close_st;
                n_seen        = 1'b0;
                n_held        = afr_pkg::HELD_NONE;
            end
            afr_pkg::CLS_BUF_END: begin
                n_line.mask   = '1;
                n_line.pos    = '0;
                n_line.status = afr_pkg::ST_PENDING;
                n_seen        = 1'b0;
                n_held        = afr_pkg::HELD_NONE;
            end
            default: begin
                n_line = r_line;
            end
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_status_out = r_status_out;
        n_done_out   = r_done_out;
        if (o_pop) begin
            n_out_valid  = 1'b1;
            n_done_out   = (i_item.cls == afr_pkg::CLS_BUF_END);
            n_status_out = (i_item.cls == afr_pkg::CLS_BUF_END) ? close_st : n_line.status;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line.mask   <= '1;
            r_line.pos    <= '0;
            r_line.status <= afr_pkg::ST_PENDING;
            r_seen        <= 1'b0;
            r_held        <= afr_pkg::HELD_NONE;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_line <= n_line;
                r_seen <= n_seen;
                r_held <= n_held;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status_out <= n_status_out;
        r_done_out   <= n_done_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = 2'(r_status_out);
    assign o_buffer_done = r_done_out;

    a_buf_end_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_item.cls == afr_pkg::CLS_BUF_END)) |=>
        ((r_line.status == afr_pkg::ST_PENDING) && (r_line.mask == '1) &&
         (r_line.pos == '0) && !r_seen && (r_held == afr_pkg::HELD_NONE)))
        else $error("end of buffer did not clear line state");

    a_status_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_line.status != afr_pkg::ST_PENDING) &&
         !(o_pop && (i_item.cls == afr_pkg::CLS_BUF_END))) |=>
        (r_line.status == $past(r_line.status)))
        else $error("decided status changed before end of buffer");

    a_held_needs_content : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != afr_pkg::HELD_NONE) |-> r_seen)
        else $error("whitespace held on a line without content");

endmodule

`default_nettype wire

/* rtl/at_final_result_detector.sv */
// An accepted transaction is written to the queue; its result is registered in the
// output register when the back end takes it. Throughput: one transaction per cycle
// unless the queue is full; the back end applies one queued item per cycle unless
// the output stalls, and the output register drains while the next item is taken.
// Reset (synchronous, active low) empties the queue and the output register,
// sets the status to pending and clears the line state. No clearing pass.
`default_nettype none

module at_final_result_detector #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_status,
    output logic            o_buffer_done
);

    afr_pkg::t_item        push_item;
    afr_pkg::t_item        head_item;
    afr_pkg::t_queue_flags flags;
    logic                  push;
    logic                  pop;

    afr_front u_front (
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_rx_byte  (i_rx_byte),
        .i_flags    (flags),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_item     (push_item)
    );

    afr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_flags (flags)
    );

    afr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_flags       (flags),
        .i_item        (head_item),
        .i_out_stall   (i_out_stall),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_buffer_done (o_buffer_done)
    );

endmodule

`default_nettype wire
